// ----- design/asre_pkg.sv -----
`default_nettype none

package asre_pkg;

  localparam int unsigned SampleW = 10;
  localparam int unsigned NeutralW = 9;
  localparam int unsigned FullW = 9;
  localparam int unsigned DelayW = 8;
  localparam int unsigned CfgDataW = 9;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ModeW = 3;
  localparam int unsigned EventW = 3;
  localparam int unsigned PosW = 12;

  localparam logic signed [PosW-1:0] Center = 12'sd512;
  localparam logic signed [PosW-1:0] Margin = 12'sd50;

  localparam logic [NeutralW-1:0] NeutralReset = 9'd100;
  localparam logic [FullW-1:0] FullReset = 9'd350;
  localparam logic [DelayW-1:0] DelayReset = 8'd4;
  localparam logic [DelayW-1:0] DelayMax = 8'd255;

  typedef enum logic [CfgIdxW-1:0] {
    REG_NEUTRAL = 2'd0,
    REG_FULL = 2'd1,
    REG_DELAY = 2'd2
  } reg_idx_t;

  typedef enum logic [7:0] {
    ST_INIT = 8'b0000_0001,
    ST_WAIT = 8'b0000_0010,
    ST_TINC = 8'b0000_0100,
    ST_INC = 8'b0000_1000,
    ST_OK = 8'b0001_0000,
    ST_TDEC = 8'b0010_0000,
    ST_DEC = 8'b0100_0000,
    ST_CANCEL = 8'b1000_0000
  } state_t;

  typedef enum logic [ModeW-1:0] {
    MODE_INIT = 3'd0,
    MODE_WAIT = 3'd1,
    MODE_TINC = 3'd2,
    MODE_INC = 3'd3,
    MODE_OK = 3'd4,
    MODE_TDEC = 3'd5,
    MODE_DEC = 3'd6,
    MODE_CANCEL = 3'd7
  } mode_t;

  typedef enum logic [EventW-1:0] {
    EV_NONE = 3'd0,
    EV_INC = 3'd1,
    EV_DEC = 3'd2,
    EV_OK = 3'd3,
    EV_CANCEL = 3'd4
  } event_t;

  function automatic mode_t mode_code(input state_t s);
    mode_t m;
    m = MODE_INIT;
    unique case (s)
      ST_INIT: m = MODE_INIT;
      ST_WAIT: m = MODE_WAIT;
      ST_TINC: m = MODE_TINC;
      ST_INC: m = MODE_INC;
      ST_OK: m = MODE_OK;
      ST_TDEC: m = MODE_TDEC;
      ST_DEC: m = MODE_DEC;
      ST_CANCEL: m = MODE_CANCEL;
      default: m = MODE_INIT;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- design/analog_stick_repeat_events.sv -----
// channel  direction  handshake             payload
// in_      input      in_valid / in_ready   in_func, in_sample
// out_     output     out_valid / out_ready out_mode, out_event_res
// cfg_     input      cfg_we                cfg_index, cfg_data
//
// One transaction per cycle unless the output stalls; its result appears in the output register in the next cycle.
// Throughput is set by the single output register: outside reset in_ready is high whenever
// it is empty or being drained in the same cycle.
// A stalled output holds its result and holds off the input side.
// Reset (rst_n low at a clock edge) restores init mode, a zero delay count and the
// register defaults; no clearing pass follows.
`default_nettype none

module analog_stick_repeat_events #(
  parameter int unsigned NEUTRAL_RESET = asre_pkg::NeutralReset,
  parameter int unsigned FULL_RESET = asre_pkg::FullReset,
  parameter int unsigned DELAY_RESET = asre_pkg::DelayReset
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_func,
  input  wire logic [asre_pkg::SampleW-1:0]   in_sample,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [asre_pkg::ModeW-1:0]          out_mode,
  output logic [asre_pkg::EventW-1:0]         out_event_res,
  input  wire logic                           cfg_we,
  input  wire logic [asre_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [asre_pkg::CfgDataW-1:0]  cfg_data
);

  logic [asre_pkg::NeutralW-1:0] neutral_r;
  logic [asre_pkg::FullW-1:0] full_r;
  logic [asre_pkg::DelayW-1:0] delay_r;
  asre_pkg::state_t state_r, state_nxt;
  logic [asre_pkg::DelayW-1:0] dcount_r, dcount_nxt;
  asre_pkg::event_t ev_nxt;
  logic out_valid_r;
  logic [asre_pkg::ModeW-1:0] out_mode_r;
  logic [asre_pkg::EventW-1:0] out_event_r;
  logic in_fire;

  logic signed [asre_pkg::PosW-1:0] pos;
  logic signed [asre_pkg::PosW-1:0] nt_s, neg_nt, enter_s, neg_enter, full_s, neg_full;
  logic elapsed;

  assign in_ready = rst_n && (!out_valid_r || out_ready);
  assign in_fire = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_mode = out_mode_r;
  assign out_event_res = out_event_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neutral_r <= asre_pkg::NeutralW'(NEUTRAL_RESET);
      full_r <= asre_pkg::FullW'(FULL_RESET);
      delay_r <= asre_pkg::DelayW'(DELAY_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        asre_pkg::REG_NEUTRAL: neutral_r <= cfg_data[asre_pkg::NeutralW-1:0];
        asre_pkg::REG_FULL: full_r <= cfg_data[asre_pkg::FullW-1:0];
        asre_pkg::REG_DELAY: delay_r <= cfg_data[asre_pkg::DelayW-1:0];
        default: ;
      endcase
    end
  end

  assign pos = $signed({2'b00, in_sample}) - asre_pkg::Center;
  assign nt_s = $signed({3'b000, neutral_r});
  assign neg_nt = -nt_s;
  assign enter_s = nt_s + asre_pkg::Margin;
  assign neg_enter = -enter_s;
  assign full_s = $signed({3'b000, full_r}) + asre_pkg::Margin;
  assign neg_full = -full_s;
  assign elapsed = dcount_r >= delay_r;

  always_comb begin
    state_nxt = state_r;
    dcount_nxt = dcount_r;
    ev_nxt = asre_pkg::EV_NONE;
    if (in_func) begin
      if (dcount_r != asre_pkg::DelayMax) begin
        dcount_nxt = dcount_r + 1'b1;
      end
    end else begin
      unique case (state_r)
        asre_pkg::ST_INIT: begin
          if (pos > neg_nt && pos < nt_s) begin
            state_nxt = asre_pkg::ST_WAIT;
          end
        end
        asre_pkg::ST_WAIT: begin
          if (pos >= enter_s) begin
            state_nxt = asre_pkg::ST_TINC;
            dcount_nxt = '0;
          end else if (pos <= neg_enter) begin
            state_nxt = asre_pkg::ST_TDEC;
            dcount_nxt = '0;
          end
        end
        asre_pkg::ST_TINC: begin
          if (pos < nt_s) begin
            state_nxt = asre_pkg::ST_WAIT;
            ev_nxt = asre_pkg::EV_INC;
          end else if (elapsed) begin
            state_nxt = asre_pkg::ST_INC;
            dcount_nxt = '0;
            ev_nxt = asre_pkg::EV_INC;
          end else if (pos >= full_s) begin
            state_nxt = asre_pkg::ST_OK;
            ev_nxt = asre_pkg::EV_OK;
          end
        end
        asre_pkg::ST_INC: begin
          if (pos < nt_s) begin
            state_nxt = asre_pkg::ST_WAIT;
          end else if (elapsed) begin
            dcount_nxt = '0;
            ev_nxt = asre_pkg::EV_INC;
          end
        end
        asre_pkg::ST_OK: begin
          if (pos < nt_s) begin
            state_nxt = asre_pkg::ST_WAIT;
          end
        end
        asre_pkg::ST_TDEC: begin
          if (pos > neg_nt) begin
            state_nxt = asre_pkg::ST_WAIT;
            ev_nxt = asre_pkg::EV_DEC;
          end else if (elapsed) begin
            state_nxt = asre_pkg::ST_DEC;
            dcount_nxt = '0;
            ev_nxt = asre_pkg::EV_DEC;
          end else if (pos <= neg_full) begin
            state_nxt = asre_pkg::ST_CANCEL;
            ev_nxt = asre_pkg::EV_CANCEL;
          end
        end
        asre_pkg::ST_DEC: begin
          if (pos > neg_nt) begin
            state_nxt = asre_pkg::ST_WAIT;
          end else if (elapsed) begin
            dcount_nxt = '0;
            ev_nxt = asre_pkg::EV_DEC;
          end
        end
        asre_pkg::ST_CANCEL: begin
          if (pos > neg_nt) begin
            state_nxt = asre_pkg::ST_WAIT;
          end
        end
        default: state_nxt = asre_pkg::ST_INIT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= asre_pkg::ST_INIT;
      dcount_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r <= state_nxt;
        dcount_r <= dcount_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_mode_r <= asre_pkg::mode_code(state_nxt);
      out_event_r <= ev_nxt;
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("stick state lost its one-hot code");

  a_tick_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_func) |=> ($stable(state_r) && out_event_r == asre_pkg::EV_NONE))
    else $error("tick changed the mode or raised an event");

  a_delay_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_func && dcount_r == asre_pkg::DelayMax) |=>
      dcount_r == asre_pkg::DelayMax)
    else $error("delay count wrapped");

  a_ok_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_event_r == asre_pkg::EV_OK) |-> out_mode_r == asre_pkg::MODE_OK)
    else $error("ok event outside ok mode");

  a_cancel_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_event_r == asre_pkg::EV_CANCEL) |->
      out_mode_r == asre_pkg::MODE_CANCEL)
    else $error("cancel event outside cancel mode");

  a_out_mirrors_state: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_fire) |-> out_mode_r == asre_pkg::mode_code(state_r))
    else $error("result mode differs from stick state");

endmodule

`default_nettype wire

// ----- tb/tb_analog_stick_repeat_events.sv -----
module tb_analog_stick_repeat_events;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DirRows = 23;
  localparam int NumPhases = 8;
  localparam int PhaseItems = 178;
  localparam logic [asre_pkg::CfgIdxW-1:0] RegUnused = 2'd3;

  typedef struct packed {
    asre_pkg::mode_t mode;
    asre_pkg::event_t ev;
  } stick_res_t;

  typedef struct packed {
    logic func;
    logic [asre_pkg::SampleW-1:0] sample;
    bit typed;
    stick_res_t res;
  } dir_row_t;

  typedef struct packed {
    logic [asre_pkg::CfgDataW-1:0] neutral;
    logic [asre_pkg::CfgDataW-1:0] full;
    logic [asre_pkg::CfgDataW-1:0] delay;
    bit quiet;
    bit shuffle;
  } phase_t;

  localparam stick_res_t Predicted = '{asre_pkg::MODE_INIT, asre_pkg::EV_NONE};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_func = 1'b0;
  logic [asre_pkg::SampleW-1:0] in_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [asre_pkg::ModeW-1:0] out_mode;
  logic [asre_pkg::EventW-1:0] out_event_res;
  logic cfg_we = 1'b0;
  logic [asre_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [asre_pkg::CfgDataW-1:0] cfg_data = '0;

  asre_pkg::mode_t pred_mode = asre_pkg::MODE_INIT;
  logic [asre_pkg::DelayW-1:0] pred_delay = '0;
  logic [asre_pkg::NeutralW-1:0] neutral_lvl = asre_pkg::NeutralReset;
  logic [asre_pkg::FullW-1:0] full_lvl = asre_pkg::FullReset;
  logic [asre_pkg::DelayW-1:0] repeat_lvl = asre_pkg::DelayReset;

  stick_res_t pending_q[$];
  int mismatches = 0;
  bit quiet = 1'b0;

  dir_row_t dir_rows [DirRows];
  phase_t phases [NumPhases];

  analog_stick_repeat_events u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_func(in_func),
    .in_sample(in_sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_mode(out_mode),
    .out_event_res(out_event_res),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic stick_res_t step_stick(input logic f,
                                            input logic [asre_pkg::SampleW-1:0] s);
    int pos;
    int nt;
    int enter_lvl;
    int ok_lvl;
    bit elapsed;
    asre_pkg::event_t ev;
    ev = asre_pkg::EV_NONE;
    if (f) begin
      if (pred_delay != asre_pkg::DelayMax) pred_delay = pred_delay + 1'b1;
    end else begin
      pos = int'(s) - int'(asre_pkg::Center);
      nt = int'(neutral_lvl);
      enter_lvl = nt + int'(asre_pkg::Margin);
      ok_lvl = int'(full_lvl) + int'(asre_pkg::Margin);
      elapsed = (pred_delay >= repeat_lvl);
      case (pred_mode)
        asre_pkg::MODE_INIT: begin
          if (pos > -nt && pos < nt) pred_mode = asre_pkg::MODE_WAIT;
        end
        asre_pkg::MODE_WAIT: begin
          if (pos >= enter_lvl) begin
            pred_mode = asre_pkg::MODE_TINC;
            pred_delay = '0;
          end else if (pos <= -enter_lvl) begin
            pred_mode = asre_pkg::MODE_TDEC;
            pred_delay = '0;
          end
        end
        asre_pkg::MODE_TINC: begin
          if (pos < nt) begin
            pred_mode = asre_pkg::MODE_WAIT;
            ev = asre_pkg::EV_INC;
          end else if (elapsed) begin
            pred_mode = asre_pkg::MODE_INC;
            pred_delay = '0;
            ev = asre_pkg::EV_INC;
          end else if (pos >= ok_lvl) begin
            pred_mode = asre_pkg::MODE_OK;
            ev = asre_pkg::EV_OK;
          end
        end
        asre_pkg::MODE_INC: begin
          if (pos < nt) begin
            pred_mode = asre_pkg::MODE_WAIT;
          end else if (elapsed) begin
            pred_delay = '0;
            ev = asre_pkg::EV_INC;
          end
        end
        asre_pkg::MODE_OK: begin
          if (pos < nt) pred_mode = asre_pkg::MODE_WAIT;
        end
        asre_pkg::MODE_TDEC: begin
          if (pos > -nt) begin
            pred_mode = asre_pkg::MODE_WAIT;
            ev = asre_pkg::EV_DEC;
          end else if (elapsed) begin
            pred_mode = asre_pkg::MODE_DEC;
            pred_delay = '0;
            ev = asre_pkg::EV_DEC;
          end else if (pos <= -ok_lvl) begin
            pred_mode = asre_pkg::MODE_CANCEL;
            ev = asre_pkg::EV_CANCEL;
          end
        end
        asre_pkg::MODE_DEC: begin
          if (pos > -nt) begin
            pred_mode = asre_pkg::MODE_WAIT;
          end else if (elapsed) begin
            pred_delay = '0;
            ev = asre_pkg::EV_DEC;
          end
        end
        default: begin
          if (pos > -nt) pred_mode = asre_pkg::MODE_WAIT;
        end
      endcase
    end
    return '{pred_mode, ev};
  endfunction

  function automatic logic [asre_pkg::SampleW-1:0] to_sample(input int p);
    int v;
    v = p + int'(asre_pkg::Center);
    if (v < 0) v = 0;
    if (v > (1 << asre_pkg::SampleW) - 1) v = (1 << asre_pkg::SampleW) - 1;
    return v[asre_pkg::SampleW-1:0];
  endfunction

  function automatic int pick_pos();
    int nt;
    int enter_lvl;
    int ok_lvl;
    int p;
    nt = int'(neutral_lvl);
    enter_lvl = nt + int'(asre_pkg::Margin);
    ok_lvl = int'(full_lvl) + int'(asre_pkg::Margin);
    case ($urandom_range(9))
      0, 1: p = (nt > 1) ? int'($urandom_range(nt - 1)) : 0;
      2, 3, 4: p = enter_lvl + int'($urandom_range(120));
      5, 6: p = ok_lvl + int'($urandom_range(100));
      7, 8: begin
        case ($urandom_range(5))
          0: p = nt;
          1: p = nt - 1;
          2: p = enter_lvl;
          3: p = enter_lvl - 1;
          4: p = ok_lvl;
          default: p = ok_lvl - 1;
        endcase
      end
      default: p = int'($urandom_range(1023)) - int'(asre_pkg::Center);
    endcase
    if ($urandom_range(1)) p = -p;
    return p;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("%0t: mismatch: %s", $realtime, what);
  endtask

  task automatic drive_item(input logic f, input logic [asre_pkg::SampleW-1:0] s,
                            input bit typed = 1'b0, input stick_res_t typed_res = '0);
    stick_res_t pred;
    while (!quiet && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    pred = step_stick(f, s);
    pending_q.push_back(typed ? typed_res : pred);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [asre_pkg::CfgIdxW-1:0] idx,
                           input logic [asre_pkg::CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    case (idx)
      asre_pkg::REG_NEUTRAL: neutral_lvl = data[asre_pkg::NeutralW-1:0];
      asre_pkg::REG_FULL: full_lvl = data[asre_pkg::FullW-1:0];
      asre_pkg::REG_DELAY: repeat_lvl = data[asre_pkg::DelayW-1:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  always @(negedge clk) out_ready <= quiet || ($urandom_range(99) >= 19);

  always @(posedge clk) begin : check_results
    stick_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result mode %0d event %0d",
                                out_mode, out_event_res));
      end else begin
        want = pending_q.pop_front();
        if (out_mode !== want.mode)
          flag_mismatch($sformatf("mode %0d, expected %0d", out_mode, want.mode));
        if (out_event_res !== want.ev)
          flag_mismatch($sformatf("event %0d, expected %0d", out_event_res, want.ev));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int sent;
    int n;
    int p;
    int len;
    logic [asre_pkg::SampleW-1:0] rs;
    phase_t ph;

    dir_rows = '{
      '{1'b1, 10'd0,    1'b1, '{asre_pkg::MODE_INIT, asre_pkg::EV_NONE}},
      '{1'b0, 10'd0,    1'b1, '{asre_pkg::MODE_INIT, asre_pkg::EV_NONE}},
      '{1'b0, 10'd1023, 1'b1, '{asre_pkg::MODE_INIT, asre_pkg::EV_NONE}},
      '{1'b0, 10'd512,  1'b1, '{asre_pkg::MODE_WAIT, asre_pkg::EV_NONE}},
      '{1'b0, 10'd662,  1'b0, Predicted},
      '{1'b0, 10'd612,  1'b0, Predicted},
      '{1'b0, 10'd611,  1'b0, Predicted},
      '{1'b0, 10'd362,  1'b0, Predicted},
      '{1'b0, 10'd412,  1'b0, Predicted},
      '{1'b0, 10'd413,  1'b0, Predicted},
      '{1'b0, 10'd1023, 1'b0, Predicted},
      '{1'b0, 10'd1023, 1'b0, Predicted},
      '{1'b0, 10'd512,  1'b0, Predicted},
      '{1'b0, 10'd0,    1'b0, Predicted},
      '{1'b0, 10'd0,    1'b0, Predicted},
      '{1'b0, 10'd512,  1'b0, Predicted},
      '{1'b0, 10'd700,  1'b0, Predicted},
      '{1'b1, 10'd1023, 1'b0, Predicted},
      '{1'b1, 10'd341,  1'b0, Predicted},
      '{1'b1, 10'd682,  1'b0, Predicted},
      '{1'b1, 10'd0,    1'b0, Predicted},
      '{1'b0, 10'd700,  1'b0, Predicted},
      '{1'b0, 10'd512,  1'b0, Predicted}
    };

    phases = '{
      '{9'd0,   9'd0,   9'd0,   1'b0, 1'b0},
      '{9'd60,  9'd200, 9'd2,   1'b1, 1'b0},
      '{9'd511, 9'd511, 9'd255, 1'b0, 1'b0},
      '{9'd150, 9'd100, 9'd1,   1'b0, 1'b0},
      '{9'd0,   9'd0,   9'd0,   1'b0, 1'b1},
      '{9'd20,  9'd461, 9'd8,   1'b0, 1'b0},
      '{9'd0,   9'd0,   9'd0,   1'b0, 1'b1},
      '{9'd461, 9'd0,   9'd511, 1'b0, 1'b0}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i])
      drive_item(dir_rows[i].func, dir_rows[i].sample, dir_rows[i].typed, dir_rows[i].res);
    settle();

    foreach (phases[k]) begin
      ph = phases[k];
      if (ph.shuffle) begin
        ph.neutral = asre_pkg::CfgDataW'($urandom_range(461));
        ph.full = asre_pkg::CfgDataW'($urandom_range(461));
        ph.delay = asre_pkg::CfgDataW'($urandom_range(511));
      end
      cfg_write(asre_pkg::REG_NEUTRAL, ph.neutral);
      cfg_write(asre_pkg::REG_FULL, ph.full);
      cfg_write(asre_pkg::REG_DELAY, ph.delay);
      cfg_write(RegUnused, asre_pkg::CfgDataW'($urandom_range(511)));
      cfg_we <= 1'b0;
      quiet = ph.quiet;
      sent = 0;
      while (sent < PhaseItems) begin
        if ($urandom_range(99) < 8) begin
          n = $urandom_range(1, int'(repeat_lvl) + 2);
          repeat (n) begin
            rs = asre_pkg::SampleW'($urandom_range(1023));
            drive_item(1'b1, rs);
            sent++;
          end
        end else begin
          p = pick_pos();
          len = $urandom_range(1, 10);
          repeat (len) begin
            if ($urandom_range(99) < 40) begin
              rs = asre_pkg::SampleW'($urandom_range(1023));
              drive_item(1'b1, rs);
            end else begin
              drive_item(1'b0, to_sample(p));
            end
            sent++;
          end
        end
      end
      settle();
      quiet = 1'b0;
    end

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
